>>> src/bsu_pkg.sv
// Shared types, widths and constant tables for the banker's sequence unrank unit.
package bsu_pkg;

  localparam int MW               = 32;  // position and mask width
  localparam int SW               = 6;   // set size register width
  localparam int BW               = 30;  // binomial coefficient width, C(32,16) < 2^30
  localparam int PW               = 36;  // coefficient times a factor of up to 32
  localparam int SHW              = 3;   // shift amount for a divisor of up to 32
  localparam int DEN_W            = 6;
  localparam int DEN_MAX          = 32;
  localparam int MAX_ELEMENTS_DEF = 32;
  localparam logic [SW-1:0] SET_SIZE_RESET = 6'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEVEL_CHK,
    ST_LEVEL_DIV,
    ST_START_DIV,
    ST_EMIT_CHK,
    ST_EMIT_DIV,
    ST_DONE
  } bsu_state_t;

  typedef struct packed {
    logic load;
    logic lvl_step;
    logic start_mul;
    logic emit_take;
    logic emit_skip;
    logic div;
  } bsu_cmd_t;

  typedef struct packed {
    logic oor;
    logic lvl_done;
    logic c_zero;
    logic emit_done;
    logic take;
  } bsu_status_t;

  typedef logic [DEN_MAX:0][SHW-1:0] shift_tab_t;
  typedef logic [DEN_MAX:0][BW-1:0]  inv_tab_t;

  // Inverse of an odd value modulo 2^BW by Newton iteration; each pass doubles
  // the number of correct low bits, starting from three.
  function automatic logic [BW-1:0] odd_inverse(input logic [BW-1:0] o);
    logic [BW-1:0] x;
    x = o;
    for (int k = 0; k < 5; k++) begin
      x = x * (BW'(2) - o * x);
    end
    return x;
  endfunction

  function automatic shift_tab_t build_shift_tab();
    shift_tab_t tab;
    int         d;
    int         s;
    tab = '0;
    for (d = 1; d <= DEN_MAX; d++) begin
      s = 0;
      while (((d >> s) & 1) == 0) s++;
      tab[d] = SHW'(s);
    end
    return tab;
  endfunction

  function automatic inv_tab_t build_inv_tab();
    inv_tab_t tab;
    int       d;
    int       s;
    tab = '0;
    for (d = 1; d <= DEN_MAX; d++) begin
      s = 0;
      while (((d >> s) & 1) == 0) s++;
      tab[d] = odd_inverse(BW'(d >> s));
    end
    return tab;
  endfunction

  // A divisor d = 2^s * o splits into a right shift by s and a multiply by
  // the inverse of o, which is exact because every quotient here is exact.
  localparam shift_tab_t SHIFT_TAB = build_shift_tab();
  localparam inv_tab_t   INV_TAB   = build_inv_tab();

endpackage

>>> src/bsu_ctrl.sv
// Controller state machine for the banker's sequence unrank unit.
module bsu_ctrl import bsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  bsu_status_t status,
  output bsu_cmd_t    cmd,
  output logic        busy,
  output logic        done
);

  bsu_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_LEVEL_CHK;
      end
      ST_LEVEL_CHK: begin
        if (status.oor) begin
          state_next = ST_DONE;
        end else if (status.lvl_done) begin
          state_next = status.c_zero ? ST_DONE : ST_START_DIV;
        end else begin
          state_next = ST_LEVEL_DIV;
        end
      end
      ST_LEVEL_DIV: state_next = ST_LEVEL_CHK;
      ST_START_DIV: state_next = ST_EMIT_CHK;
      ST_EMIT_CHK: begin
        state_next = status.emit_done ? ST_DONE : ST_EMIT_DIV;
      end
      ST_EMIT_DIV: state_next = ST_EMIT_CHK;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_LEVEL_CHK: begin
        if (!status.oor) begin
          if (status.lvl_done) begin
            cmd.start_mul = !status.c_zero;
          end else begin
            cmd.lvl_step = 1'b1;
          end
        end
      end
      ST_LEVEL_DIV: cmd.div = 1'b1;
      ST_START_DIV: cmd.div = 1'b1;
      ST_EMIT_CHK: begin
        if (!status.emit_done) begin
          cmd.emit_take = status.take;
          cmd.emit_skip = !status.take;
        end
      end
      ST_EMIT_DIV: cmd.div = 1'b1;
      ST_DONE:     done = 1'b1;
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted item did not make the unit busy");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command issued");

endmodule

>>> src/bsu_datapath.sv
// Datapath of the banker's sequence unrank unit: counters, offset, coefficient unit, mask.
module bsu_datapath import bsu_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SW-1:0]     cfg_data,
  input  logic [MW-1:0]     position,
  input  bsu_cmd_t          cmd,
  output bsu_status_t       status,
  output logic [MW-1:0]     subset_mask,
  output logic              out_of_range
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  logic [SW-1:0]    set_size;
  logic [CW-1:0]    n_q;
  logic [CW-1:0]    c_q;
  logic [CW-1:0]    i_q;
  logic             oor_q;
  logic [MW-1:0]    e_q;
  logic [BW-1:0]    b_q;
  logic [PW-1:0]    prod_q;
  logic [SHW-1:0]   shift_q;
  logic [BW-1:0]    inv_q;
  logic [MW-1:0]    mask_q;

  logic [CW-1:0]    n_sat;
  logic             oor_calc;
  logic [CW-1:0]    num;
  logic [CW-1:0]    den;
  logic [DEN_W-1:0] den_idx;
  logic [PW-1:0]    prod_next;
  logic [PW-1:0]    shifted;
  logic [BW-1:0]    quot;
  logic [MW-1:0]    b_ext;

  always_comb begin
    if (set_size > SW'(MAX_ELEMENTS)) begin
      n_sat = CW'(MAX_ELEMENTS);
    end else begin
      n_sat = set_size[CW-1:0];
    end
  end

  assign oor_calc = (position >> n_sat) != '0;

  // Factor and divisor that step the current coefficient to the next one needed.
  always_comb begin
    num = '0;
    den = '0;
    if (cmd.lvl_step) begin
      num = n_q - c_q;
      den = c_q + CW'(1);
    end else if (cmd.start_mul) begin
      num = c_q;
      den = n_q;
    end else if (cmd.emit_take) begin
      num = c_q - CW'(1);
      den = i_q - CW'(1);
    end else if (cmd.emit_skip) begin
      num = i_q - c_q;
      den = i_q - CW'(1);
    end
  end

  assign den_idx   = DEN_W'(den);
  assign prod_next = PW'(b_q) * PW'(num);
  assign shifted   = prod_q >> shift_q;
  assign quot      = BW'(shifted[BW-1:0] * inv_q);
  assign b_ext     = MW'(b_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      set_size <= SET_SIZE_RESET;
      n_q      <= '0;
      c_q      <= '0;
      i_q      <= '0;
      oor_q    <= 1'b0;
    end else begin
      if (cfg_we) set_size <= cfg_data;
      if (cmd.load) begin
        n_q   <= n_sat;
        c_q   <= '0;
        i_q   <= n_sat;
        oor_q <= oor_calc;
      end else if (cmd.lvl_step) begin
        c_q <= c_q + CW'(1);
      end else if (cmd.emit_take) begin
        c_q <= c_q - CW'(1);
        i_q <= i_q - CW'(1);
      end else if (cmd.emit_skip) begin
        i_q <= i_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e_q    <= position;
      b_q    <= BW'(1);
      mask_q <= '0;
    end else begin
      if (cmd.lvl_step || cmd.emit_skip) e_q <= e_q - b_ext;
      if (cmd.emit_take) mask_q <= mask_q | (MW'(1) << (i_q - CW'(1)));
      if (cmd.div) b_q <= quot;
    end
    if (cmd.lvl_step || cmd.start_mul || cmd.emit_take || cmd.emit_skip) begin
      prod_q  <= prod_next;
      shift_q <= SHIFT_TAB[den_idx];
      inv_q   <= INV_TAB[den_idx];
    end
  end

  assign status.oor       = oor_q;
  assign status.lvl_done  = (c_q >= n_q) || (e_q < b_ext);
  assign status.c_zero    = (c_q == '0);
  assign status.emit_done = (i_q == '0) || (c_q == '0);
  assign status.take      = (e_q == '0) || (b_ext > e_q);

  assign subset_mask  = mask_q;
  assign out_of_range = oor_q;

  a_c_bounded: assert property (@(posedge clk) disable iff (rst) c_q <= n_q)
    else $error("subset size count exceeds the set size");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (mask_q == '0 && c_q == '0))
    else $error("item start did not clear the mask and size count");

endmodule

>>> src/bankers_sequence_unrank_unit.sv
// Top level of the banker's sequence unrank unit.
//
// Usage: write set_size through cfg_we/cfg_data while the unit is idle; reset
// sets it to 32 and values above MAX_ELEMENTS act as MAX_ELEMENTS. An item
// (position) is taken at a clock edge with start high and busy low. The unit
// finds the subset size by subtracting binomial coefficients, then walks the
// elements from bit n-1 down, taking or skipping each one.
// The result (subset_mask, out_of_range) shows for exactly one cycle with
// done high; the receiver cannot stall it, so it must take it then.
// A position of 2^n or more gives a zero mask with out_of_range set.
// Each step goes through one shared coefficient unit (a multiply by a small
// factor, registered, then an exact division by a small divisor done as a
// multiply by its inverse). busy drops in the cycle after done, so the next
// item can be accepted then. Reset returns the controller to idle with no
// result pending.
module bankers_sequence_unrank_unit import bsu_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [SW-1:0] cfg_data,
  input  logic          start,
  input  logic [MW-1:0] position,
  output logic          busy,
  output logic          done,
  output logic [MW-1:0] subset_mask,
  output logic          out_of_range
);

  bsu_cmd_t    cmd;
  bsu_status_t status;

  bsu_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  bsu_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .position     (position),
    .cmd          (cmd),
    .status       (status),
    .subset_mask  (subset_mask),
    .out_of_range (out_of_range)
  );

  a_oor_zero_mask: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_range) |-> (subset_mask == '0))
    else $error("out of range item delivered with a nonzero mask");

endmodule

>>> verif/tb_bankers_sequence_unrank_unit.sv
// Self-checking testbench for the banker's sequence unrank unit.
module tb_bankers_sequence_unrank_unit;
  import bsu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_GAP        = 30;

  typedef struct {
    logic [MW-1:0] mask;
    logic          oor;
  } subset_t;

  logic          clk          = 1'b0;
  logic          rst          = 1'b1;
  logic          cfg_we       = 1'b0;
  logic [SW-1:0] cfg_data     = '0;
  logic          start        = 1'b0;
  logic [MW-1:0] position     = '0;
  logic          busy;
  logic          done;
  logic [MW-1:0] subset_mask;
  logic          out_of_range;

  logic [SW-1:0] set_size_shadow = SET_SIZE_RESET;
  subset_t       expected_subsets[$];
  int            error_count = 0;
  int            idle_cycles = 0;
  int            idle_pct    = 0;

  bankers_sequence_unrank_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .start        (start),
    .position     (position),
    .busy         (busy),
    .done         (done),
    .subset_mask  (subset_mask),
    .out_of_range (out_of_range)
  );

  always #10 clk = ~clk;

  function automatic longint unsigned choose(input int unsigned n, input int unsigned k);
    longint unsigned r;
    int unsigned     kk;
    r = 1;
    if (k > n) return 0;
    kk = (k > n - k) ? n - k : k;
    for (int unsigned t = 0; t < kk; t++) r = (r * (n - t)) / (t + 1);
    return r;
  endfunction

  function automatic int unsigned active_elements(input logic [SW-1:0] sz);
    return (sz > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : int'(sz);
  endfunction

  // Strip whole size classes off the position, then decide each element from
  // the top bit down against the count of subsets that still fit below it.
  function automatic subset_t predict_subset(input logic [MW-1:0] pos, input logic [SW-1:0] sz);
    subset_t         res;
    int unsigned     n;
    int unsigned     c;
    longint unsigned offset;
    longint unsigned b;
    n = active_elements(sz);
    res.mask = '0;
    res.oor  = 1'b0;
    if (longint'(pos) >= (longint'(1) << n)) begin
      res.oor = 1'b1;
      return res;
    end
    offset = pos;
    c = 0;
    while (c < n) begin
      b = choose(n, c);
      if (offset < b) break;
      offset -= b;
      c++;
    end
    for (int unsigned i = n; i > 0 && c > 0; i--) begin
      b = choose(i - 1, c - 1);
      if (offset == 0 || b > offset) begin
        res.mask[i-1] = 1'b1;
        c--;
      end else begin
        offset -= b;
      end
    end
    return res;
  endfunction

  // Check each result against the oldest prediction.
  always @(posedge clk) begin
    subset_t exp_res;
    if (!rst && done) begin
      if (expected_subsets.size() == 0) begin
        $error("unexpected result: subset_mask %h out_of_range %b", subset_mask, out_of_range);
        error_count++;
      end else begin
        exp_res = expected_subsets.pop_front();
        if (subset_mask !== exp_res.mask) begin
          $error("subset_mask: expected %h, got %h", exp_res.mask, subset_mask);
          error_count++;
        end
        if (out_of_range !== exp_res.oor) begin
          $error("out_of_range: expected %b, got %b", exp_res.oor, out_of_range);
          error_count++;
        end
      end
    end
  end

  // Watchdog over cycles in which no item and no result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Start stays high after acceptance so back-to-back items need no toggle.
  task automatic send_position(input logic [MW-1:0] pos);
    int gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do begin
        @(posedge clk);
        gap++;
      end while ($urandom_range(99) < idle_pct && gap < MAX_GAP);
    end
    start    <= 1'b1;
    position <= pos;
    do @(posedge clk); while (busy);
    expected_subsets.push_back(predict_subset(pos, set_size_shadow));
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_subsets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_set_size(input logic [SW-1:0] sz);
    wait_for_results();
    cfg_we   <= 1'b1;
    cfg_data <= sz;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_size_shadow = sz;
  endtask

  task automatic test_full_set_extremes();
    idle_pct = 0;
    send_position(32'd0);
    send_position(32'd1);
    send_position(32'd32);
    send_position(32'd33);
    send_position(32'h8000_0000);
    send_position(32'hAAAA_AAAA);
    send_position(32'h5555_5555);
    send_position(32'hFFFF_FFFF);
  endtask

  task automatic test_small_and_odd_sizes();
    write_set_size(6'd1);
    send_position(32'd0);
    send_position(32'd1);
    send_position(32'd2);
    // An empty set has only the empty subset.
    write_set_size(6'd0);
    send_position(32'd0);
    send_position(32'd1);
    // Sizes beyond the element count behave as the full set.
    write_set_size(6'd63);
    send_position(32'hFFFF_FFFF);
    send_position(32'd5);
    write_set_size(6'd3);
    for (int p = 0; p <= 8; p++) send_position(MW'(p));
  endtask

  task automatic test_random_positions();
    logic [SW-1:0] sizes[12];
    int            pcts[4];
    int unsigned   n;
    logic [MW-1:0] pos;
    sizes = '{6'd32, 6'd1, 6'd16, 6'd5, 6'd31, 6'd0, 6'd40, 6'd8, 6'd24, 6'd2, 6'd63, 6'd12};
    pcts  = '{0, 61, 23, 0};
    foreach (sizes[ph]) begin
      write_set_size(sizes[ph]);
      idle_pct = pcts[ph % 4];
      n = active_elements(sizes[ph]);
      for (int k = 0; k < 50; k++) begin
        pos = $urandom;
        if (n < MW) begin
          if ($urandom_range(99) < 75) begin
            pos = pos & ((MW'(1) << n) - 1);
            if ($urandom_range(9) == 0) pos = (MW'(1) << n) - 1;
          end else if (pos < (MW'(1) << n)) begin
            pos[$urandom_range(MW - 1, n)] = 1'b1;
          end
        end
        send_position(pos);
        if (ph == 2 && k == 25) wait_for_results();
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_full_set_extremes();
    test_small_and_odd_sizes();
    test_random_positions();
    wait_for_results();
    if (expected_subsets.size() != 0) begin
      $error("%0d results never arrived", expected_subsets.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
